// ===== src/cess_pkg.sv =====
`default_nettype none
package cess_pkg;

   // Coordinate width of points, eraser centre and the changed area
   localparam int COORD_WIDTH = 16;
   // Width of the stroke width register and of the squared radius
   localparam int SWW   = 12;
   localparam int RADW  = 32;

   // Coordinate differences and the shared multiplier
   localparam int DW    = COORD_WIDTH + 1;
   localparam int LW    = 33;
   localparam int PW    = 2 * LW;

   // Sums of two squares (unsigned) and of two signed products
   localparam int SQW   = 2 * COORD_WIDTH + 2;
   localparam int SGW   = 2 * COORD_WIDTH + 4;
   // Cross product magnitude, kept up to 64 bits
   localparam int CMW   = (SGW > 64) ? 64 : SGW;
   localparam int NLC   = (CMW + LW - 1) / LW;
   localparam int NLL   = (SQW + LW - 1) / LW;
   localparam int C2W   = 2 * CMW;
   localparam int RLW   = SQW + RADW;

   // Shared accumulator width
   localparam int MAXA  = (C2W > RLW) ? C2W : RLW;
   localparam int MAXB  = (MAXA > SGW) ? MAXA : SGW;
   localparam int ACCW  = ((MAXB > PW) ? MAXB : PW) + 1;

   // Limb counters and limb shift counts
   localparam int NLMAX = (NLC > NLL) ? NLC : NLL;
   localparam int LCW   = $clog2(NLMAX + 1);
   localparam int SHMAX = (2 * (NLC - 1) > NLL - 1) ? 2 * (NLC - 1) : NLL - 1;
   localparam int SHW   = $clog2(SHMAX + 2);

   // Widening of the area edges before saturation
   localparam int EXW   = ((COORD_WIDTH > SWW) ? COORD_WIDTH : SWW) + 2;

   // Stream and register port widths
   localparam int REQ_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 4 + 4 * COORD_WIDTH;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DW       = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X     = 2'd0,
      CSR_CENTER_Y     = 2'd1,
      CSR_RADIUS_SQ    = 2'd2,
      CSR_STROKE_WIDTH = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_MUL,
      S_DRAIN,
      S_CHECK,
      S_SQ,
      S_RL,
      S_DRAIN2,
      S_CMP,
      S_DONE
   } seg_state_type;

   // Products of the first pass, in issue order
   typedef enum logic [3:0] {
      OP_D0X  = 4'd0,
      OP_D0Y  = 4'd1,
      OP_D1X  = 4'd2,
      OP_D1Y  = 4'd3,
      OP_L2X  = 4'd4,
      OP_L2Y  = 4'd5,
      OP_DOTX = 4'd6,
      OP_DOTY = 4'd7,
      OP_CRSA = 4'd8,
      OP_CRSB = 4'd9
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_D0,
      ACC_D1,
      ACC_L2,
      ACC_DOT,
      ACC_CROSS,
      ACC_C2,
      ACC_RL2
   } acc_target_type;

   typedef struct packed {
      acc_target_type   tgt;
      logic             set_acc;
      logic             neg;
      logic [SHW-1:0]   shift;
   } acc_tag_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic [RADW-1:0]               rsq;
      logic [SWW-1:0]                width;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic                          first_point;
      logic                          last_point;
   } item_type;

   typedef struct packed {
      logic ready;
      logic done;
      logic hit;
   } seg_status_type;

   typedef struct packed {
      logic                          segment_valid;
      logic                          segment_hit;
      logic                          cut_before;
      logic                          resume_at;
      logic                          stroke_done;
      logic                          area_valid;
      logic signed [COORD_WIDTH-1:0] area_min_x;
      logic signed [COORD_WIDTH-1:0] area_min_y;
      logic signed [COORD_WIDTH-1:0] area_max_x;
      logic signed [COORD_WIDTH-1:0] area_max_y;
   } result_type;

endpackage
`default_nettype wire

// ===== src/cess_mul.sv =====
`default_nettype none
module cess_mul (
   input  logic                        clock,
   input  logic                        mul_en,
   input  logic [cess_pkg::LW-1:0]     mul_a,
   input  logic [cess_pkg::LW-1:0]     mul_b,
   output logic [cess_pkg::PW-1:0]     prod
);

   logic [cess_pkg::PW-1:0] prod_ff;
   logic [cess_pkg::PW-1:0] prod_in;

   // Unsigned product of two magnitudes
   assign prod_in = cess_pkg::PW'(mul_a) * cess_pkg::PW'(mul_b);

   // Register the product before it reaches the accumulator
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== src/cess_seg.sv =====
`default_nettype none
module cess_seg (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  cess_pkg::item_type                     item_in,
   input  cess_pkg::cfg_type                      cfg,
   input  logic signed [cess_pkg::COORD_WIDTH-1:0] prev_x,
   input  logic signed [cess_pkg::COORD_WIDTH-1:0] prev_y,
   input  logic                                   commit,
   output cess_pkg::item_type                     item,
   output cess_pkg::seg_status_type               status
);

   localparam int DW   = cess_pkg::DW;
   localparam int LW   = cess_pkg::LW;
   localparam int ACCW = cess_pkg::ACCW;
   localparam int LCW  = cess_pkg::LCW;
   localparam int SHW  = cess_pkg::SHW;

   cess_pkg::seg_state_type state_ff, state_in;
   cess_pkg::mul_op_type    op_ff, op_in;
   logic [LCW-1:0]          i_ff, i_in, j_ff, j_in;
   logic                    acc_v_ff;
   cess_pkg::acc_tag_type   tag_ff, tag_in;
   logic                    mul_en;
   logic [LW-1:0]           mul_a, mul_b;
   logic [cess_pkg::PW-1:0] prod;

   cess_pkg::item_type      item_ff;
   logic signed [DW-1:0]    dx0_ff, dy0_ff, dx1_ff, dy1_ff, lx_ff, ly_ff;
   logic [cess_pkg::SQW-1:0] d0_ff, d1_ff, l2_ff;
   logic signed [cess_pkg::SGW-1:0] dot_ff, cross_ff;
   logic [cess_pkg::C2W-1:0] c2_ff;
   logic [cess_pkg::RLW-1:0] rl2_ff;
   logic [cess_pkg::NLC*LW-1:0] cm_ff;
   logic                    hit_ff;

   logic signed [DW-1:0]    sa, sb;
   logic                    op_sub;
   logic [cess_pkg::NLL*LW-1:0] l2pad;
   logic [ACCW-1:0]         base, addend, sum;
   logic                    in0, in1, dot_pos, dot_lt, cross_big, early;
   logic [cess_pkg::SGW-1:0] cmag;
   logic                    sq_last_i, sq_last_j, rl_last;

   function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
      mag_of = v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   assign l2pad = (cess_pkg::NLL*LW)'(l2_ff);

   // Tests on the first-pass sums
   assign in0       = ACCW'(d0_ff) < ACCW'(cfg.rsq);
   assign in1       = ACCW'(d1_ff) < ACCW'(cfg.rsq);
   assign dot_pos   = !dot_ff[cess_pkg::SGW-1] && (dot_ff != '0);
   assign dot_lt    = ACCW'(dot_ff) < ACCW'(l2_ff);
   assign cmag      = cross_ff[cess_pkg::SGW-1] ? cess_pkg::SGW'(-cross_ff)
                                                : cess_pkg::SGW'(cross_ff);
   assign cross_big = |(cmag >> 64);
   assign early     = in0 || in1 || !(dot_pos && dot_lt) || cross_big;

   assign sq_last_i = (i_ff == LCW'(cess_pkg::NLC - 1));
   assign sq_last_j = (j_ff == LCW'(cess_pkg::NLC - 1));
   assign rl_last   = (i_ff == LCW'(cess_pkg::NLL - 1));

   // Sequencer: next state and counters
   always_comb begin
      state_in = state_ff;
      op_in    = cess_pkg::OP_D0X;
      i_in     = '0;
      j_in     = '0;
      case (state_ff)
         cess_pkg::S_IDLE: begin
            if (accept) begin
               state_in = item_in.first_point ? cess_pkg::S_DONE : cess_pkg::S_DIFF;
            end
         end
         cess_pkg::S_DIFF: begin
            state_in = cess_pkg::S_MUL;
         end
         cess_pkg::S_MUL: begin
            if (op_ff == cess_pkg::OP_CRSB) begin
               state_in = cess_pkg::S_DRAIN;
            end else begin
               op_in = cess_pkg::mul_op_type'(op_ff + 4'd1);
            end
         end
         cess_pkg::S_DRAIN: begin
            state_in = cess_pkg::S_CHECK;
         end
         cess_pkg::S_CHECK: begin
            state_in = early ? cess_pkg::S_DONE : cess_pkg::S_SQ;
         end
         cess_pkg::S_SQ: begin
            if (sq_last_j) begin
               if (sq_last_i) begin
                  state_in = cess_pkg::S_RL;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               i_in = i_ff;
               j_in = j_ff + 1'b1;
            end
         end
         cess_pkg::S_RL: begin
            if (rl_last) begin
               state_in = cess_pkg::S_DRAIN2;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         cess_pkg::S_DRAIN2: begin
            state_in = cess_pkg::S_CMP;
         end
         cess_pkg::S_CMP: begin
            state_in = cess_pkg::S_DONE;
         end
         cess_pkg::S_DONE: begin
            if (commit) begin
               state_in = cess_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cess_pkg::S_IDLE;
         end
      endcase
   end

   // First-pass operand table
   always_comb begin
      sa         = dx0_ff;
      sb         = dx0_ff;
      op_sub     = 1'b0;
      tag_in.tgt = cess_pkg::ACC_D0;
      case (op_ff)
         cess_pkg::OP_D0X:  begin sa = dx0_ff; sb = dx0_ff; tag_in.tgt = cess_pkg::ACC_D0; end
         cess_pkg::OP_D0Y:  begin sa = dy0_ff; sb = dy0_ff; tag_in.tgt = cess_pkg::ACC_D0; end
         cess_pkg::OP_D1X:  begin sa = dx1_ff; sb = dx1_ff; tag_in.tgt = cess_pkg::ACC_D1; end
         cess_pkg::OP_D1Y:  begin sa = dy1_ff; sb = dy1_ff; tag_in.tgt = cess_pkg::ACC_D1; end
         cess_pkg::OP_L2X:  begin sa = lx_ff;  sb = lx_ff;  tag_in.tgt = cess_pkg::ACC_L2; end
         cess_pkg::OP_L2Y:  begin sa = ly_ff;  sb = ly_ff;  tag_in.tgt = cess_pkg::ACC_L2; end
         cess_pkg::OP_DOTX: begin sa = lx_ff;  sb = dx0_ff; tag_in.tgt = cess_pkg::ACC_DOT; end
         cess_pkg::OP_DOTY: begin sa = ly_ff;  sb = dy0_ff; tag_in.tgt = cess_pkg::ACC_DOT; end
         cess_pkg::OP_CRSA: begin sa = lx_ff;  sb = dy0_ff; tag_in.tgt = cess_pkg::ACC_CROSS; end
         cess_pkg::OP_CRSB: begin
            sa         = ly_ff;
            sb         = dx0_ff;
            op_sub     = 1'b1;
            tag_in.tgt = cess_pkg::ACC_CROSS;
         end
         default: begin
            sa = dx0_ff;
         end
      endcase

      // Issue one product per cycle to the shared multiplier
      mul_en         = 1'b0;
      mul_a          = LW'(mag_of(sa));
      mul_b          = LW'(mag_of(sb));
      tag_in.set_acc = !op_ff[0];
      tag_in.neg     = sa[DW-1] ^ sb[DW-1] ^ op_sub;
      tag_in.shift   = '0;
      case (state_ff)
         cess_pkg::S_MUL: begin
            mul_en = 1'b1;
         end
         cess_pkg::S_SQ: begin
            mul_en         = 1'b1;
            mul_a          = cm_ff[i_ff*LW +: LW];
            mul_b          = cm_ff[j_ff*LW +: LW];
            tag_in.tgt     = cess_pkg::ACC_C2;
            tag_in.set_acc = (i_ff == '0) && (j_ff == '0);
            tag_in.neg     = 1'b0;
            tag_in.shift   = SHW'(i_ff) + SHW'(j_ff);
         end
         cess_pkg::S_RL: begin
            mul_en         = 1'b1;
            mul_a          = l2pad[i_ff*LW +: LW];
            mul_b          = LW'(cfg.rsq);
            tag_in.tgt     = cess_pkg::ACC_RL2;
            tag_in.set_acc = (i_ff == '0);
            tag_in.neg     = 1'b0;
            tag_in.shift   = SHW'(i_ff);
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   cess_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod   (prod)
   );

   // Shared accumulator: add or subtract the shifted product
   always_comb begin
      case (tag_ff.tgt)
         cess_pkg::ACC_D0:    base = ACCW'(d0_ff);
         cess_pkg::ACC_D1:    base = ACCW'(d1_ff);
         cess_pkg::ACC_L2:    base = ACCW'(l2_ff);
         cess_pkg::ACC_DOT:   base = ACCW'(dot_ff);
         cess_pkg::ACC_CROSS: base = ACCW'(cross_ff);
         cess_pkg::ACC_C2:    base = ACCW'(c2_ff);
         cess_pkg::ACC_RL2:   base = ACCW'(rl2_ff);
         default:             base = '0;
      endcase
      if (tag_ff.set_acc) begin
         base = '0;
      end
      addend = ACCW'(prod) << (LW * tag_ff.shift);
      sum    = tag_ff.neg ? base - addend : base + addend;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cess_pkg::S_IDLE;
         op_ff    <= cess_pkg::OP_D0X;
         i_ff     <= '0;
         j_ff     <= '0;
         acc_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         acc_v_ff <= mul_en;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (mul_en) begin
         tag_ff <= tag_in;
      end
      if (accept) begin
         item_ff <= item_in;
         hit_ff  <= 1'b0;
      end
      if (state_ff == cess_pkg::S_DIFF) begin
         dx0_ff <= DW'(cfg.cx) - DW'(prev_x);
         dy0_ff <= DW'(cfg.cy) - DW'(prev_y);
         dx1_ff <= DW'(cfg.cx) - DW'(item_ff.x);
         dy1_ff <= DW'(cfg.cy) - DW'(item_ff.y);
         lx_ff  <= DW'(item_ff.x) - DW'(prev_x);
         ly_ff  <= DW'(item_ff.y) - DW'(prev_y);
      end
      if (acc_v_ff) begin
         case (tag_ff.tgt)
            cess_pkg::ACC_D0:    d0_ff    <= sum[cess_pkg::SQW-1:0];
            cess_pkg::ACC_D1:    d1_ff    <= sum[cess_pkg::SQW-1:0];
            cess_pkg::ACC_L2:    l2_ff    <= sum[cess_pkg::SQW-1:0];
            cess_pkg::ACC_DOT:   dot_ff   <= signed'(sum[cess_pkg::SGW-1:0]);
            cess_pkg::ACC_CROSS: cross_ff <= signed'(sum[cess_pkg::SGW-1:0]);
            cess_pkg::ACC_C2:    c2_ff    <= sum[cess_pkg::C2W-1:0];
            cess_pkg::ACC_RL2:   rl2_ff   <= sum[cess_pkg::RLW-1:0];
            default:             d0_ff    <= d0_ff;
         endcase
      end
      if (state_ff == cess_pkg::S_CHECK) begin
         hit_ff <= in0 || in1;
         cm_ff  <= (cess_pkg::NLC*LW)'(cmag);
      end
      if (state_ff == cess_pkg::S_CMP) begin
         hit_ff <= ACCW'(c2_ff) < ACCW'(rl2_ff);
      end
   end

   assign item         = item_ff;
   assign status.ready = (state_ff == cess_pkg::S_IDLE);
   assign status.done  = (state_ff == cess_pkg::S_DONE);
   assign status.hit   = hit_ff;

endmodule
`default_nettype wire

// ===== src/cess_box.sv =====
`default_nettype none
module cess_box (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    commit,
   input  cess_pkg::item_type                      item,
   input  cess_pkg::seg_status_type                status,
   input  logic [cess_pkg::SWW-1:0]                stroke_width,
   output logic signed [cess_pkg::COORD_WIDTH-1:0] prev_x,
   output logic signed [cess_pkg::COORD_WIDTH-1:0] prev_y,
   output cess_pkg::result_type                    result
);

   localparam int W   = cess_pkg::COORD_WIDTH;
   localparam int EXW = cess_pkg::EXW;
   localparam logic signed [EXW-1:0] CMAX = {{(EXW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [EXW-1:0] CMIN = {{(EXW-W+1){1'b1}}, {(W-1){1'b0}}};

   logic signed [W-1:0] prev_x_ff, prev_y_ff;
   logic                erasing_ff, box_valid_ff;
   logic signed [W-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   logic                seg_valid, hit, box_valid_new;
   logic signed [W-1:0] lo_x, lo_y, hi_x, hi_y;
   logic signed [W-1:0] nmin_x, nmin_y, nmax_x, nmax_y;
   logic signed [W-1:0] amin_x, amin_y, amax_x, amax_y;
   logic signed [EXW-1:0] wext;

   function automatic logic signed [W-1:0] min2(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      min2 = (a < b) ? a : b;
   endfunction

   function automatic logic signed [W-1:0] max2(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      max2 = (a > b) ? a : b;
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [EXW-1:0] v);
      if (v > CMAX) begin
         sat = CMAX[W-1:0];
      end else if (v < CMIN) begin
         sat = CMIN[W-1:0];
      end else begin
         sat = v[W-1:0];
      end
   endfunction

   assign seg_valid = !item.first_point;
   assign hit       = seg_valid && status.hit;

   // Grow the hit box by both segment ends
   assign lo_x   = min2(prev_x_ff, item.x);
   assign lo_y   = min2(prev_y_ff, item.y);
   assign hi_x   = max2(prev_x_ff, item.x);
   assign hi_y   = max2(prev_y_ff, item.y);
   assign nmin_x = box_valid_ff ? min2(min_x_ff, lo_x) : lo_x;
   assign nmin_y = box_valid_ff ? min2(min_y_ff, lo_y) : lo_y;
   assign nmax_x = box_valid_ff ? max2(max_x_ff, hi_x) : hi_x;
   assign nmax_y = box_valid_ff ? max2(max_y_ff, hi_y) : hi_y;

   assign box_valid_new = seg_valid && (hit || box_valid_ff);
   assign amin_x = hit ? nmin_x : min_x_ff;
   assign amin_y = hit ? nmin_y : min_y_ff;
   assign amax_x = hit ? nmax_x : max_x_ff;
   assign amax_y = hit ? nmax_y : max_y_ff;
   assign wext   = signed'(EXW'(stroke_width));

   // Form the result for the current point
   always_comb begin
      result.segment_valid = seg_valid;
      result.segment_hit   = hit;
      result.cut_before    = hit && !erasing_ff;
      result.resume_at     = seg_valid && !hit && erasing_ff;
      result.stroke_done   = item.last_point;
      result.area_valid    = item.last_point && box_valid_new;
      result.area_min_x    = '0;
      result.area_min_y    = '0;
      result.area_max_x    = '0;
      result.area_max_y    = '0;
      if (result.area_valid) begin
         result.area_min_x = sat(EXW'(amin_x) - wext);
         result.area_min_y = sat(EXW'(amin_y) - wext);
         result.area_max_x = sat(EXW'(amax_x) + wext);
         result.area_max_y = sat(EXW'(amax_y) + wext);
      end
   end

   // Piece and area state, advanced when the result is taken into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         erasing_ff   <= 1'b0;
         box_valid_ff <= 1'b0;
      end else if (commit) begin
         prev_x_ff    <= item.x;
         prev_y_ff    <= item.y;
         erasing_ff   <= hit && !item.last_point;
         box_valid_ff <= box_valid_new && !item.last_point;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && hit) begin
         min_x_ff <= nmin_x;
         min_y_ff <= nmin_y;
         max_x_ff <= nmax_x;
         max_y_ff <= nmax_y;
      end
   end

   assign prev_x = prev_x_ff;
   assign prev_y = prev_y_ff;

endmodule
`default_nettype wire

// ===== src/circle_eraser_stroke_splitter.sv =====
// Channel   Direction  Transfer condition       Contents
// req_*     in         req_tvalid & req_tready  one stroke point
// rsp_*     out        rsp_tvalid & rsp_tready  one segment / stroke result
// csr_*     in         csr_we                   eraser and stroke registers
//
// A point whose segment the first-pass tests settle needs no cross-product
// test; otherwise the cross-product test adds four limb squares and two limb
// products. A first point goes straight from transfer to its result. Every
// product is formed by the single 33x33 multiplier that they all share.
// Reset is synchronous and needs no clearing pass. A result waiting on
// rsp_tready does not block the next point; only its own finish stalls.
`default_nettype none
module circle_eraser_stroke_splitter (
   input  logic                                clock,
   input  logic                                reset,
   // point_x, point_y
   input  logic [cess_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // first_point
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // segment_hit, cut_before, resume_at, area_valid,
   // area_min_x, area_min_y, area_max_x, area_max_y
   output logic [cess_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // segment_valid
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [cess_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cess_pkg::CSR_DW-1:0]         csr_wdata
);

   localparam int W = cess_pkg::COORD_WIDTH;

   cess_pkg::cfg_type        cfg_ff;
   cess_pkg::item_type       item_in, item;
   cess_pkg::seg_status_type status;
   cess_pkg::result_type     result, res_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accept, commit;
   logic signed [W-1:0]      prev_x, prev_y;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (cess_pkg::csr_index_type'(csr_index))
            cess_pkg::CSR_CENTER_X:     cfg_ff.cx    <= signed'(csr_wdata[W-1:0]);
            cess_pkg::CSR_CENTER_Y:     cfg_ff.cy    <= signed'(csr_wdata[W-1:0]);
            cess_pkg::CSR_RADIUS_SQ:    cfg_ff.rsq   <= csr_wdata[cess_pkg::RADW-1:0];
            cess_pkg::CSR_STROKE_WIDTH: cfg_ff.width <= csr_wdata[cess_pkg::SWW-1:0];
            default:                    cfg_ff       <= cfg_ff;
         endcase
      end
   end

   assign item_in.x           = signed'(req_tdata[W-1:0]);
   assign item_in.y           = signed'(req_tdata[2*W-1:W]);
   assign item_in.first_point = req_tuser;
   assign item_in.last_point  = req_tlast;

   assign req_tready = status.ready;
   assign accept     = req_tvalid && status.ready;
   assign commit     = status.done && (!rsp_valid_ff || rsp_tready);

   cess_seg u_seg (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item_in (item_in),
      .cfg     (cfg_ff),
      .prev_x  (prev_x),
      .prev_y  (prev_y),
      .commit  (commit),
      .item    (item),
      .status  (status)
   );

   cess_box u_box (
      .clock        (clock),
      .reset        (reset),
      .commit       (commit),
      .item         (item),
      .status       (status),
      .stroke_width (cfg_ff.width),
      .prev_x       (prev_x),
      .prev_y       (prev_y),
      .result       (result)
   );

   // Output register: hold until transferred
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = res_ff.segment_valid;
   assign rsp_tlast  = res_ff.stroke_done;
   assign rsp_tdata  = cess_pkg::RSP_TDATA_W'({res_ff.area_max_y, res_ff.area_max_x,
                                               res_ff.area_min_y, res_ff.area_min_x,
                                               res_ff.area_valid, res_ff.resume_at,
                                               res_ff.cut_before, res_ff.segment_hit});

endmodule
`default_nettype wire

// ===== src/cess_check.sv =====
`default_nettype none
module cess_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cess_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [cess_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                rsp_tuser,
   input  logic                                rsp_tlast,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [cess_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cess_pkg::CSR_DW-1:0]         csr_wdata
);

   // A stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // One point at a time: no transfer right after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("point taken while another is in work");

   // Segment flags stay clear without a tested segment
   a_seg_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[2:0] == 3'b000)
      else $error("segment flags without a segment");

   // Area only on the last point of a stroke
   a_area_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tdata[3])
      else $error("area valid before stroke end");

   // A piece cannot both end and resume at the same point
   a_cut_resume: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("cut and resume together");

endmodule

bind circle_eraser_stroke_splitter cess_check u_cess_check (.*);
`default_nettype wire
